// ----- rtl/ppj_pkg.sv -----
`timescale 1ns / 1ps
package ppj_pkg;

  localparam int IMAGE_WIDTH  = 120;
  localparam int IMAGE_HEIGHT = 120;

  localparam int COL_BITS  = $clog2(IMAGE_WIDTH);
  localparam int ROW_BITS  = $clog2(IMAGE_HEIGHT);
  localparam int Q_BITS    = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
  localparam int GRAY_BITS = 8;
  localparam int NUM_CELLS = (Q_BITS > GRAY_BITS) ? Q_BITS : GRAY_BITS;
  localparam int BIT_W     = $clog2(NUM_CELLS);

  localparam int DIV_W = 18;
  localparam int REM_W = DIV_W + Q_BITS;
  localparam int N_W   = 28;
  localparam int A_W   = 29;
  localparam int T_W   = 23;
  localparam int S_W   = 32;
  localparam int S65_W = 48;

  typedef enum logic [1:0] {
    REG_FOCAL = 2'd0,
    REG_NEAR  = 2'd1,
    REG_FAR   = 2'd2
  } ppj_reg_e;

  typedef struct packed {
    logic [9:0]  focal;
    logic [14:0] near_d;
    logic [14:0] far_d;
  } ppj_cfg_t;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic              wr;
    logic              gzero;
    logic [REM_W-1:0]  col_rem;
    logic [Q_BITS-1:0] col_q;
    logic [REM_W-1:0]  row_rem;
    logic [Q_BITS-1:0] row_q;
    logic [DIV_W-1:0]  div;
    logic [T_W-1:0]    t;
    logic [14:0]       dd;
    logic [S65_W-1:0]  s65;
    logic [7:0]        g;
  } ppj_cell_t;

endpackage

// ----- rtl/ppj_front.sv -----
`timescale 1ns / 1ps
module ppj_front import ppj_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  logic [15:0]     point_x_i,
  input  logic [15:0]     point_y_i,
  input  logic [15:0]     point_z_i,
  input  logic            point_valid_i,
  input  logic            last_point_i,
  input  ppj_cfg_t        cfg_i,
  output ppj_cell_t       cell_o
);

  typedef struct packed {
    logic             ok;
    logic [REM_W-1:0] rem;
  } ppj_axis_t;

  function automatic ppj_axis_t prep(input logic signed [N_W-1:0] n,
                                     input logic [16:0] den, input int size);
    ppj_axis_t r;
    logic [A_W-1:0] a;
    logic [A_W-1:0] lim;
    r   = '0;
    lim = A_W'({den, 1'b0}) * A_W'(size);
    if (n < 0) begin
      a     = A_W'(-n) << 1;
      r.ok  = a < A_W'(den);
      r.rem = '0;
    end else begin
      a     = (A_W'(n) << 1) + A_W'(den);
      r.ok  = a < lim;
      r.rem = r.ok ? REM_W'(a) : '0;
    end
    return r;
  endfunction

  logic               s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic signed [15:0] x_q, y_q, z_q, z2_q;
  logic               pv_q, pv2_q, pv3_q;
  logic               last_q, last2_q, last3_q;
  logic [31:0]        sqx_q, sqy_q, sqz_q;
  logic signed [26:0] fx_q, fy_q;
  logic [S_W-1:0]     s_q;
  logic signed [N_W-1:0] nx_q, ny_q;
  logic [16:0]        den_q;
  logic               zero_q;
  ppj_cell_t          c_d, c_q;

  logic signed [N_W-1:0] z_ext, nx_d, ny_d;
  logic [15:0]        zabs;
  logic signed [31:0] px, py, pz;
  logic [29:0]        far_sq, near_sq;
  ppj_axis_t          ax, ay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= acc_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_comb begin
    px = x_q * x_q;
    py = y_q * y_q;
    pz = z_q * z_q;
  end

  always_ff @(posedge clk_i) begin
    x_q    <= point_x_i;
    y_q    <= point_y_i;
    z_q    <= point_z_i;
    pv_q   <= point_valid_i;
    last_q <= last_point_i;
    sqx_q  <= 32'(px);
    sqy_q  <= 32'(py);
    sqz_q  <= 32'(pz);
    fx_q   <= $signed({1'b0, cfg_i.focal}) * x_q;
    fy_q   <= $signed({1'b0, cfg_i.focal}) * y_q;
    z2_q   <= z_q;
    pv2_q  <= pv_q;
    last2_q <= last_q;
  end

  always_comb begin
    z_ext = N_W'(z2_q);
    nx_d  = z_ext * $signed(N_W'(IMAGE_WIDTH)) + (N_W'(fx_q) <<< 1);
    ny_d  = z_ext * $signed(N_W'(IMAGE_HEIGHT)) + (N_W'(fy_q) <<< 1);
    zabs  = z2_q;
    if (z2_q < 0) begin
      nx_d = -nx_d;
      ny_d = -ny_d;
      zabs = 16'(-z2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= sqx_q + sqy_q + sqz_q;
    nx_q    <= nx_d;
    ny_q    <= ny_d;
    den_q   <= {zabs, 1'b0};
    zero_q  <= z2_q == 16'sd0;
    pv3_q   <= pv2_q;
    last3_q <= last2_q;
  end

  always_comb begin
    far_sq  = 30'(cfg_i.far_d) * 30'(cfg_i.far_d);
    near_sq = 30'(cfg_i.near_d) * 30'(cfg_i.near_d);
    ax      = prep(nx_q, den_q, IMAGE_WIDTH);
    ay      = prep(ny_q, den_q, IMAGE_HEIGHT);
    c_d         = '0;
    c_d.vld     = s3_vld_q;
    c_d.last    = last3_q;
    c_d.wr      = pv3_q && !zero_q && ax.ok && ay.ok;
    c_d.gzero   = (cfg_i.far_d <= cfg_i.near_d) || (s_q > S_W'(far_sq))
                  || (s_q < S_W'(near_sq));
    c_d.col_rem = ax.rem;
    c_d.row_rem = ay.rem;
    c_d.div     = DIV_W'({den_q, 1'b0});
    c_d.t       = T_W'(cfg_i.far_d) * T_W'(255);
    c_d.dd      = cfg_i.far_d - cfg_i.near_d;
    c_d.s65     = S65_W'(s_q) * S65_W'(65025);
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  always_comb begin
    cell_o     = c_q;
    cell_o.vld = s4_vld_q;
  end

endmodule

// ----- rtl/ppj_cell.sv -----
`timescale 1ns / 1ps
module ppj_cell import ppj_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [BIT_W-1:0] bit_i,
  input  ppj_cell_t        cell_i,
  output ppj_cell_t        cell_o
);

  ppj_cell_t        cell_d, cell_q;
  logic             vld_q;
  logic [REM_W-1:0] step_e;
  logic [T_W-1:0]   tt;
  logic [45:0]      sq;

  always_comb begin
    cell_d = cell_i;
    step_e = REM_W'(cell_i.div) << bit_i;
    tt     = cell_i.t - (T_W'(cell_i.dd) << bit_i);
    sq     = 46'(tt) * 46'(tt);
    if (32'(bit_i) < Q_BITS) begin
      if (cell_i.col_rem >= step_e) begin
        cell_d.col_rem = cell_i.col_rem - step_e;
        cell_d.col_q   = cell_i.col_q | (Q_BITS'(1) << bit_i);
      end
      if (cell_i.row_rem >= step_e) begin
        cell_d.row_rem = cell_i.row_rem - step_e;
        cell_d.row_q   = cell_i.row_q | (Q_BITS'(1) << bit_i);
      end
    end
    if (32'(bit_i) < GRAY_BITS) begin
      if (S65_W'(sq) >= cell_i.s65) begin
        cell_d.t = tt;
        cell_d.g = cell_i.g | (8'(1) << bit_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  always_comb begin
    cell_o     = cell_q;
    cell_o.vld = vld_q;
  end

endmodule

// ----- rtl/point_to_depth_pixel_projector.sv -----
`timescale 1ns / 1ps
// Throughput: one point per cycle; busy stays low, the pipeline never stalls.
// Depth: 4 front stages (squares, sums, window and divisor setup) then one
//   cell per quotient/gray bit, then the output register.
// Reset: clears pipeline valids and loads focal 200, near 3154, far 3768.
// The receiver cannot stall; each result shows for exactly one cycle.
module point_to_depth_pixel_projector import ppj_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] point_x_i,
  input  logic [15:0] point_y_i,
  input  logic [15:0] point_z_i,
  input  logic        point_valid_i,
  input  logic        last_point_i,
  output logic        strobe,
  output logic        pixel_write_o,
  output logic [6:0]  pixel_column_o,
  output logic [6:0]  pixel_row_o,
  output logic [7:0]  gray_value_o,
  output logic        frame_end_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);

  logic [9:0]  focal_q;
  logic [14:0] near_q, far_q;
  ppj_cfg_t    cfg;
  ppj_cell_t   chain [NUM_CELLS+1];
  ppj_cell_t   fin;
  logic        strobe_q, wr_q, last_q;
  logic [6:0]  col_q, row_q;
  logic [7:0]  gray_q;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q <= 10'd200;
      near_q  <= 15'd3154;
      far_q   <= 15'd3768;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_i)
        REG_FOCAL: focal_q <= cfg_data_i[9:0];
        REG_NEAR:  near_q  <= cfg_data_i;
        REG_FAR:   far_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.focal  = focal_q;
    cfg.near_d = near_q;
    cfg.far_d  = far_q;
  end

  ppj_front u_front (
    .clk_i,
    .rst_ni,
    .acc_i         (start && !busy),
    .point_x_i,
    .point_y_i,
    .point_z_i,
    .point_valid_i,
    .last_point_i,
    .cfg_i         (cfg),
    .cell_o        (chain[0])
  );

  for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
    ppj_cell u_cell (
      .clk_i,
      .rst_ni,
      .bit_i  (BIT_W'(NUM_CELLS - 1 - gi)),
      .cell_i (chain[gi]),
      .cell_o (chain[gi+1])
    );
  end

  assign fin = chain[NUM_CELLS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= fin.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q   <= fin.wr;
    last_q <= fin.last;
    col_q  <= fin.wr ? 7'(fin.col_q) : 7'd0;
    row_q  <= fin.wr ? 7'(fin.row_q) : 7'd0;
    gray_q <= (fin.wr && !fin.gzero) ? fin.g : 8'd0;
  end

  assign strobe         = strobe_q;
  assign pixel_write_o  = wr_q;
  assign pixel_column_o = col_q;
  assign pixel_row_o    = row_q;
  assign gray_value_o   = gray_q;
  assign frame_end_o    = last_q;

  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !pixel_write_o |->
      (pixel_column_o == 7'd0 && pixel_row_o == 7'd0 && gray_value_o == 8'd0))
    else $error("fields not cleared on a transaction without pixel write");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && (far_q <= near_q) |-> gray_value_o == 8'd0)
    else $error("gray nonzero with empty range window");

  a_cfg_focal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid && cfg_index_i == REG_FOCAL) |=> focal_q == $past(cfg_data_i[9:0]))
    else $error("focal length write lost");

endmodule

// ----- sim/point_to_depth_pixel_projector_chk.sv -----
`timescale 1ns / 1ps
module point_to_depth_pixel_projector_chk import ppj_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] point_x_i,
  input  logic [15:0] point_y_i,
  input  logic [15:0] point_z_i,
  input  logic        point_valid_i,
  input  logic        last_point_i,
  input  logic        strobe,
  input  logic        pixel_write_o,
  input  logic [6:0]  pixel_column_o,
  input  logic [6:0]  pixel_row_o,
  input  logic [7:0]  gray_value_o,
  input  logic        frame_end_o,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    bit       wr;
    bit [6:0] col;
    bit [6:0] row;
    bit [7:0] gray;
    bit       fe;
  } pixel_t;

  pixel_t   expected_pixels[$];
  bit [9:0]  focal_q;
  bit [14:0] near_q;
  bit [14:0] far_q;

  function automatic longint div_round(longint num, longint den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((-2 * num + den) / (2 * den));
  endfunction

  function automatic bit [7:0] range_gray(longint unsigned sumsq);
    longint unsigned nr, fr, d, g, t;
    nr = near_q;
    fr = far_q;
    if (fr <= nr || sumsq > fr * fr || sumsq < nr * nr) return 8'd0;
    d = fr - nr;
    g = 0;
    while (g < 255) begin
      t = 255 * fr - (g + 1) * d;
      if (65025 * sumsq <= t * t) g++;
      else break;
    end
    return g[7:0];
  endfunction

  function automatic pixel_t project_point(logic [15:0] px, logic [15:0] py,
                                           logic [15:0] pz, logic v, logic l);
    pixel_t p;
    longint x, y, z, u, w;
    x = longint'($signed(px));
    y = longint'($signed(py));
    z = longint'($signed(pz));
    p = '{wr: 0, col: 0, row: 0, gray: 0, fe: l};
    if (v && z != 0) begin
      u = div_round(IMAGE_WIDTH * z + 2 * longint'(focal_q) * x, 2 * z);
      w = div_round(IMAGE_HEIGHT * z + 2 * longint'(focal_q) * y, 2 * z);
      if (u >= 0 && u < IMAGE_WIDTH && w >= 0 && w < IMAGE_HEIGHT) begin
        p.wr   = 1;
        p.col  = u[6:0];
        p.row  = w[6:0];
        p.gray = range_gray(longint'(x * x + y * y + z * z));
      end
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t e;
    if (!rst_ni) begin
      focal_q = 10'd200;
      near_q  = 15'd3154;
      far_q   = 15'd3768;
      expected_pixels.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (strobe) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel transaction", $time);
          fail_count_o++;
        end else begin
          e = expected_pixels.pop_front();
          if (pixel_write_o !== e.wr) begin
            $display("%0t: pixel_write exp %0d act %0d", $time, e.wr, pixel_write_o);
            fail_count_o++;
          end
          if (pixel_column_o !== e.col) begin
            $display("%0t: pixel_column exp %0d act %0d", $time, e.col, pixel_column_o);
            fail_count_o++;
          end
          if (pixel_row_o !== e.row) begin
            $display("%0t: pixel_row exp %0d act %0d", $time, e.row, pixel_row_o);
            fail_count_o++;
          end
          if (gray_value_o !== e.gray) begin
            $display("%0t: gray_value exp %0d act %0d", $time, e.gray, gray_value_o);
            fail_count_o++;
          end
          if (frame_end_o !== e.fe) begin
            $display("%0t: frame_end exp %0d act %0d", $time, e.fe, frame_end_o);
            fail_count_o++;
          end
        end
      end
      if (start && !busy)
        expected_pixels.insert(expected_pixels.size(),
                               project_point(point_x_i, point_y_i, point_z_i,
                                             point_valid_i, last_point_i));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_i)
          REG_FOCAL: focal_q = cfg_data_i[9:0];
          REG_NEAR:  near_q  = cfg_data_i;
          REG_FAR:   far_q   = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ----- sim/point_to_depth_pixel_projector_tb.sv -----
`timescale 1ns / 1ps
module point_to_depth_pixel_projector_tb;
  import ppj_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [15:0] point_x_i = 0, point_y_i = 0, point_z_i = 0;
  logic        point_valid_i = 0, last_point_i = 0;
  logic        strobe, pixel_write_o, frame_end_o;
  logic [6:0]  pixel_column_o, pixel_row_o;
  logic [7:0]  gray_value_o;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index_i = 0;
  logic [14:0] cfg_data_i = 0;
  int          fail_count, pending;

  int focal_now = 200, near_now = 3154, far_now = 3768;
  int burst_left = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  point_to_depth_pixel_projector i_dut (.*);

  point_to_depth_pixel_projector_chk i_chk (
    .*, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic wait_idle();
    start = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int data);
    cfg_valid   = 1;
    cfg_index_i = idx;
    cfg_data_i  = data[14:0];
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 0;
    case (idx)
      REG_FOCAL: focal_now = data & 32'h3FF;
      REG_NEAR:  near_now  = data & 32'h7FFF;
      REG_FAR:   far_now   = data & 32'h7FFF;
      default: ;
    endcase
  endtask

  task automatic configure(int f, int n, int fr);
    wait_idle();
    write_reg(REG_FOCAL, f);
    write_reg(REG_NEAR, n);
    write_reg(REG_FAR, fr);
  endtask

  task automatic send_point(int x, int y, int z, bit v, bit l);
    start         = 1;
    point_x_i     = x[15:0];
    point_y_i     = y[15:0];
    point_z_i     = z[15:0];
    point_valid_i = v;
    last_point_i  = l;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start = 0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  function automatic int clamp16(longint a);
    if (a > 32767) return 32767;
    if (a < -32768) return -32768;
    return int'(a);
  endfunction

  task automatic send_random();
    int  z, k, j, f;
    f = (focal_now == 0) ? 1 : focal_now;
    if ($urandom_range(0, 9) < 2) begin
      send_point($urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
    end else begin
      if ($urandom_range(0, 2) == 0 && far_now > 0)
        z = $urandom_range((near_now > 0) ? near_now - 1 : 0, far_now);
      else
        z = $urandom_range(1, 32767);
      if (z == 0) z = 1;
      if ($urandom_range(0, 4) == 0) z = -z;
      k = int'($urandom_range(0, 130)) - 65;
      j = int'($urandom_range(0, 130)) - 65;
      send_point(clamp16(longint'(z) * k / f), clamp16(longint'(z) * j / f), z,
                 $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    send_point(0, 0, 3300, 1, 0);
    send_point(0, 0, 3154, 1, 0);
    send_point(0, 0, 3768, 1, 1);
    send_point(0, 0, 3153, 1, 0);
    send_point(0, 0, 3769, 1, 0);
    send_point(100, -100, 3400, 0, 1);
    send_point(500, 500, 0, 1, 0);
    send_point(-32768, -32768, -32768, 1, 0);
    send_point(32767, 32767, 32767, 1, 1);
    send_point(32767, -32768, 1, 1, 0);
    send_point(-1, -1, -1, 1, 0);
    send_point(1020, -1020, 3400, 1, 0);
    send_point(-1040, 1040, 3400, 1, 0);
    send_point(-255, 255, -3400, 1, 0);
    send_point(8, 8, 1, 1, 1);
    send_point(-1, 0, 2, 1, 0);
    send_point(0, -1, 400, 1, 0);
    send_point(1, 1, 400, 1, 1);

    configure(0, 5000, 5000);
    write_reg(REG_UNUSED, 15'h7FFF);
    send_point(32767, -32768, 100, 1, 0);
    send_point(0, 0, 5000, 1, 1);
    repeat (60) send_random();

    configure(15'h7FFF, 0, 32767);
    send_point(0, 0, 0, 1, 0);
    send_point(0, 0, 32767, 1, 0);
    send_point(0, 0, 1, 1, 1);
    repeat (140) send_random();

    configure(1, 32767, 0);
    repeat (80) send_random();

    configure(200, 3154, 3768);
    repeat (120) send_random();

    for (int p = 0; p < 3; p++) begin
      configure($urandom_range(1, 1023), $urandom_range(0, 20000), $urandom_range(2000, 32767));
      repeat (80) send_random();
    end

    start = 0;
    wait_idle();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
